// ===== rtl/core/gm_switching_enumerator_unit_assert.svh =====
// Assertion macros for the switching enumerator.
// No dependencies; define SYNTHESIS to compile them out.
`ifndef GM_SWITCHING_ENUMERATOR_UNIT_ASSERT_SVH
`define GM_SWITCHING_ENUMERATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/gmse_pkg.sv =====
// Package for the switching enumerator: sizes, ops and row and index types.
// No dependencies.
package gmse_pkg;
    localparam int VERTICES = 63;
    localparam int IDX_W    = 6;
    localparam int ROW_W    = 63;
    localparam int CNT_W    = 3;
    localparam logic [IDX_W-1:0] LAST_V = IDX_W'(VERTICES - 1);
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_FIND = 1'b1;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [ROW_W-1:0] t_row;
endpackage

// ===== rtl/core/gm_switching_enumerator_unit.sv =====
// Top level of the four-vertex switching-set enumerator.
// Depends on gmse_pkg and gm_switching_enumerator_unit_assert.svh.
//
//  channel | valid    | stall    | payload
//  in      | i_valid  | o_stall  | i_op, i_row_index, i_row_bits
//  out     | o_valid  | i_stall  | o_out_row_index, o_out_row_bits, o_set_*, o_last, o_exhausted
//
// A load word writes its row when it is accepted. A find word tests subsets one at a time:
// the sequencer reads the four member rows, then does the outside pass over all rows,
// then steps the cursor; a failed member degree skips the outside pass.
// A hit emits 63 rows, each read, latched and handed off in turn; a full miss scan
// covers all 595665 subsets, one row read at a time through the single row read port.
// Sync active-low reset clears cursor, done flag and sequencer, not the rows.
// Output stall holds the emit pass in place; o_stall is high while a word is in flight.
`include "gm_switching_enumerator_unit_assert.svh"
module gm_switching_enumerator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [5:0]  i_row_index,
    input  logic [62:0] i_row_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_out_row_index,
    output logic [62:0] o_out_row_bits,
    output logic [5:0]  o_set_first,
    output logic [5:0]  o_set_second,
    output logic [5:0]  o_set_third,
    output logic [5:0]  o_set_fourth,
    output logic        o_last,
    output logic        o_exhausted
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MEMB = 3'd1; // read four member rows
    localparam logic [2:0] S_OUTS = 3'd2; // read all rows, check counts
    localparam logic [2:0] S_EMIT = 3'd3; // read row, build switched row
    localparam logic [2:0] S_OUTW = 3'd4; // result word waiting
    localparam logic [2:0] S_NEXT = 3'd5; // advance cursor after a miss

    // Row memory, one read port, registered data.
    gmse_pkg::t_row            r_rows [gmse_pkg::VERTICES];
    gmse_pkg::t_row            r_rd_row;
    gmse_pkg::t_idx            rd_addr;

    logic [2:0]      r_state;
    gmse_pkg::t_idx  r_s [4];
    logic            r_done;
    gmse_pkg::t_idx  r_ptr;       // address issued last cycle
    logic            r_pend;      // a read is in flight
    logic [1:0]      r_k;
    logic [2:0]      r_base;
    logic            r_fail, r_two;
    gmse_pkg::t_idx  r_widx;
    logic            r_pend_eq;
    logic            r_ovalid;
    gmse_pkg::t_idx  r_o_idx;
    gmse_pkg::t_row  r_o_row;
    logic            r_o_last, r_o_exh;
    gmse_pkg::t_row  r_sw_mask;   // outside vertices with count 2

    wire acc_in  = i_valid && !o_stall;
    wire acc_out = r_ovalid && !i_stall;

    function automatic logic [2:0] cnt4(input gmse_pkg::t_row row,
                                        input gmse_pkg::t_idx a, input gmse_pkg::t_idx b,
                                        input gmse_pkg::t_idx c, input gmse_pkg::t_idx d);
        cnt4 = 3'(row[a]) + 3'(row[b]) + 3'(row[c]) + 3'(row[d]);
    endfunction

    logic [2:0] rd_cnt;
    logic       rd_member;
    gmse_pkg::t_row set_mask;
    assign rd_cnt = cnt4(r_rd_row, r_s[0], r_s[1], r_s[2], r_s[3]);
    assign rd_member = (r_ptr == r_s[0]) || (r_ptr == r_s[1]) ||
                       (r_ptr == r_s[2]) || (r_ptr == r_s[3]);
    assign set_mask = (gmse_pkg::ROW_W'(1) << r_s[0]) | (gmse_pkg::ROW_W'(1) << r_s[1]) |
                      (gmse_pkg::ROW_W'(1) << r_s[2]) | (gmse_pkg::ROW_W'(1) << r_s[3]);

    // Next subset in lexicographic order.
    gmse_pkg::t_idx nx [4];
    logic           nx_ok;
    always_comb begin
        nx = r_s;
        nx_ok = 1'b1;
        if (7'(r_s[3]) + 7'd1 < 7'(gmse_pkg::VERTICES)) begin
            nx[3] = r_s[3] + 6'd1;
        end else if (7'(r_s[2]) + 7'd2 < 7'(gmse_pkg::VERTICES)) begin
            nx[2] = r_s[2] + 6'd1; nx[3] = r_s[2] + 6'd2;
        end else if (7'(r_s[1]) + 7'd3 < 7'(gmse_pkg::VERTICES)) begin
            nx[1] = r_s[1] + 6'd1; nx[2] = r_s[1] + 6'd2; nx[3] = r_s[1] + 6'd3;
        end else if (7'(r_s[0]) + 7'd4 < 7'(gmse_pkg::VERTICES)) begin
            nx[0] = r_s[0] + 6'd1; nx[1] = r_s[0] + 6'd2;
            nx[2] = r_s[0] + 6'd3; nx[3] = r_s[0] + 6'd4;
        end else begin
            nx_ok = 1'b0;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    // Read address: one row per cycle while scanning. The last member cycle
    // already issues row 0 for the outside pass.
    gmse_pkg::t_idx next_ptr;
    always_comb begin
        next_ptr = r_ptr + 6'd1;
        rd_addr  = next_ptr;
        if (r_state == S_MEMB) rd_addr = r_pend_eq ? '0 : r_s[r_k];
        if (r_state == S_IDLE || r_state == S_NEXT) rd_addr = '0;
        if (r_state == S_OUTW || r_state == S_EMIT) rd_addr = r_widx;
    end

    always_ff @(posedge i_clk) begin
        if (acc_in && i_op == gmse_pkg::OP_LOAD && i_row_index < gmse_pkg::LAST_V + 6'd1) begin
            r_rows[i_row_index] <= i_row_bits;
        end
        r_rd_row <= r_rows[rd_addr];
    end

    // Sequencer. S_MEMB: r_k is the next member to read; r_pend_eq marks
    // that the last member read has returned.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_s[0]   <= 6'd0; r_s[1] <= 6'd1; r_s[2] <= 6'd2; r_s[3] <= 6'd3;
            r_done   <= 1'b0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
            r_pend_eq <= 1'b0;
            r_o_last <= 1'b0;
            r_o_exh  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc_in && i_op == gmse_pkg::OP_LOAD) begin
                        r_s[0] <= 6'd0; r_s[1] <= 6'd1; r_s[2] <= 6'd2; r_s[3] <= 6'd3;
                        r_done <= 1'b0;
                    end else if (acc_in) begin
                        if (r_done) begin
                            r_ovalid <= 1'b1;
                            r_o_idx <= '0; r_o_row <= '0; r_o_exh <= 1'b1; r_o_last <= 1'b1;
                            r_sw_mask <= '0;
                        end
                        r_state <= r_done ? S_OUTW : S_MEMB;
                        r_k <= 2'd0; r_pend <= 1'b0; r_fail <= 1'b0; r_pend_eq <= 1'b0;
                    end
                end
                S_MEMB: begin
                    // issue member r_k; its row returns next cycle
                    r_k       <= r_k + 2'd1;
                    r_pend_eq <= (r_k == 2'd3);
                    if (r_pend && r_ptr == r_s[0]) begin
                        r_base <= 3'(r_rd_row[r_s[1]]) + 3'(r_rd_row[r_s[2]]) +
                                  3'(r_rd_row[r_s[3]]);
                    end
                    if (r_pend && r_ptr != r_s[0] && rd_cnt != r_base) begin
                        r_state <= S_NEXT; r_pend <= 1'b0;
                    end else if (r_pend && r_pend_eq) begin
                        r_state <= S_OUTS; r_ptr <= '0; r_pend <= 1'b1;
                        r_two <= 1'b0; r_sw_mask <= '0;
                    end else begin
                        r_pend <= 1'b1;
                        r_ptr  <= r_s[r_k];
                    end
                end
                S_OUTS: begin
                    // r_rd_row holds row r_ptr (issued last cycle)
                    if (!rd_member) begin
                        if (rd_cnt == 3'd1 || rd_cnt == 3'd3) r_fail <= 1'b1;
                        if (rd_cnt == 3'd2) begin
                            r_two <= 1'b1;
                            r_sw_mask[r_ptr] <= 1'b1;
                        end
                    end
                    r_ptr <= next_ptr;
                    if (r_ptr == gmse_pkg::LAST_V) begin
                        r_pend <= 1'b0;
                        if (!r_fail && !(!rd_member && (rd_cnt == 3'd1 || rd_cnt == 3'd3)) &&
                            (r_two || (!rd_member && rd_cnt == 3'd2))) begin
                            r_state <= S_EMIT; r_widx <= '0;
                            r_done <= !nx_ok;
                            r_o_exh <= 1'b0;
                        end else begin
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_EMIT: begin
                    if (r_pend) begin
                        r_ovalid <= 1'b1;
                        r_o_idx  <= r_widx;
                        r_o_last <= (r_widx == gmse_pkg::LAST_V);
                        if ((r_widx == r_s[0]) || (r_widx == r_s[1]) ||
                            (r_widx == r_s[2]) || (r_widx == r_s[3]))
                            r_o_row <= r_rd_row ^ r_sw_mask;
                        else if (r_sw_mask[r_widx])
                            r_o_row <= r_rd_row ^ set_mask;
                        else
                            r_o_row <= r_rd_row;
                        r_state <= S_OUTW;
                        r_pend <= 1'b0;
                    end else begin
                        r_pend <= 1'b1;
                    end
                end
                S_OUTW: begin
                    if (acc_out) begin
                        r_ovalid <= 1'b0;
                        if (r_o_last) begin
                            r_state <= S_IDLE;
                            if (!r_o_exh && nx_ok) r_s <= nx;
                        end else begin
                            r_widx <= r_widx + 6'd1;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_NEXT: begin
                    if (nx_ok) begin
                        r_s <= nx;
                        r_state <= S_MEMB;
                        r_k <= 2'd0; r_pend <= 1'b0; r_fail <= 1'b0; r_pend_eq <= 1'b0;
                    end else begin
                        r_done <= 1'b1;
                        r_ovalid <= 1'b1;
                        r_o_idx <= '0; r_o_row <= '0; r_o_exh <= 1'b1; r_o_last <= 1'b1;
                        r_state <= S_OUTW;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_out_row_index = r_o_idx;
    assign o_out_row_bits  = r_o_row;
    assign o_set_first     = r_o_exh ? 6'd0 : r_s[0];
    assign o_set_second    = r_o_exh ? 6'd0 : r_s[1];
    assign o_set_third     = r_o_exh ? 6'd0 : r_s[2];
    assign o_set_fourth    = r_o_exh ? 6'd0 : r_s[3];
    assign o_last          = r_o_last;
    assign o_exhausted     = r_o_exh;

    `GM_ASSERT_IMPL(a_valid_in_outw, i_clk, i_rst_n, o_valid, r_state == S_OUTW)
    `GM_ASSERT_IMPL(a_exh_last, i_clk, i_rst_n, o_valid && o_exhausted, o_last)
    `GM_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall,
                    o_valid && $stable(o_out_row_index))
endmodule
